>>> rtl/mva_pkg.sv
// ---------------------------------------------------------------------------
// mva_pkg
// Shared types and constants of the mixer voice allocator.
// ---------------------------------------------------------------------------
package mva_pkg;

  localparam int MaxVoices = 16;
  localparam int VoiceW    = $clog2(MaxVoices);
  localparam int CountW    = $clog2(MaxVoices + 1);

  localparam logic [1:0] MODE_PLAY   = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_STOPID = 2'd2;
  localparam logic [1:0] MODE_GROUP  = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_VOICE = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;

  localparam logic [1:0] REG_VOICES  = 2'd0;
  localparam logic [1:0] REG_RATE    = 2'd1;
  localparam logic [1:0] REG_DIVISOR = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  sound_index;
    logic [31:0] sample_bytes;
    logic        loop_forever;
    logic [15:0] group_tag;
    logic [31:0] now_ms;
    logic [3:0]  voice_in;
    logic [31:0] play_id_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  voice_out;
    logic        stole_voice;
    logic [31:0] play_id_out;
    logic [4:0]  freed_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_DIV2, S_SCAN, S_COMMIT, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, start first division
    logic div_step;  // one quotient bit
    logic div2_init; // start second division
    logic scan_init;
    logic scan_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic is_play;
  } sts_t;

endpackage

>>> rtl/mva_if.sv
// ---------------------------------------------------------------------------
// mva_req_if / mva_rsp_if
// Valid/ready channels carrying requests and results.
// ---------------------------------------------------------------------------
interface mva_req_if import mva_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mva_rsp_if import mva_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mixer_voice_allocator_core.sv
// ---------------------------------------------------------------------------
// mixer_voice_allocator_core
// Mixer voice allocation with stealing, APB register port.
// ---------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | mode, sound, bytes, loop, group, time, voice, id
//  rsp     | out | status, voice, stolen, id, freed count
//  apb     | in  | voices_in_use, sample_rate_hz, bytes_divisor
//
// Play runs two 42-step restoring divisions, then a scan of one voice per
// cycle, a commit and the result hand-off; other modes skip the divisions.
// One request in flight; the result is held until taken.
// rst is synchronous, clears the voice table and registers to defaults.
module mixer_voice_allocator_core import mva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mva_req_if.sink     req,
  mva_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]  voices_in_use;
  logic [17:0] sample_rate_hz;
  logic [15:0] bytes_divisor;
  cmd_t        cmd;
  sts_t        sts;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voices_in_use  <= 5'd16;
      sample_rate_hz <= 18'd44100;
      bytes_divisor  <= 16'd4;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_VOICES:  voices_in_use  <= pwdata[4:0];
        REG_RATE:    sample_rate_hz <= pwdata[17:0];
        REG_DIVISOR: bytes_divisor  <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_VOICES:  prdata = 32'(voices_in_use);
      REG_RATE:    prdata = 32'(sample_rate_hz);
      REG_DIVISOR: prdata = 32'(bytes_divisor);
      default:     prdata = '0;
    endcase
  end

  mva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mva_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_in         (req.data),
    .voices_in_use  (voices_in_use),
    .sample_rate_hz (sample_rate_hz),
    .bytes_divisor  (bytes_divisor),
    .rsp            (rsp.data)
  );

  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken with result pending");

  // a result only after a commit
  a_out_after_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.commit)) else $error("result without commit");

  // a done result with id zero and nothing freed never reports a stolen voice
  a_nonzero_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status == ST_DONE && rsp.data.freed_count == 5'd0 &&
    rsp.data.play_id_out == 32'd0 |-> rsp.data.stole_voice == 1'b0)
    else $error("play id zero");

endmodule

>>> rtl/mva_ctrl.sv
// ---------------------------------------------------------------------------
// mva_ctrl
// Sequencer: divisions, voice scan, commit, result hand-off.
// ---------------------------------------------------------------------------
module mva_ctrl import mva_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!sts.is_play) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else if (sts.div_done) begin
          cmd.div2_init = 1'b1;
          state_next    = S_DIV2;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_COMMIT;
        else               cmd.scan_step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/mva_datapath.sv
// ---------------------------------------------------------------------------
// mva_datapath
// Voice table, shift-subtract divider and sequential voice scan.
// ---------------------------------------------------------------------------
module mva_datapath import mva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  req_t        req_in,
  input  logic [4:0]  voices_in_use,
  input  logic [17:0] sample_rate_hz,
  input  logic [15:0] bytes_divisor,
  output rsp_t        rsp
);

  localparam int NumW = 42;  // 1000 * 2^32 fits 42 bits
  localparam int CntW = $clog2(NumW + 1);

  req_t req;

  // voice table
  logic [MaxVoices-1:0] busy;
  logic [MaxVoices-1:0] loops;
  logic [9:0]  vsound [MaxVoices];
  logic [15:0] vgroup [MaxVoices];
  logic [31:0] vend   [MaxVoices];  // start + length
  logic [31:0] vid    [MaxVoices];
  logic [31:0] id_counter;

  // divider
  logic [NumW-1:0] quo;
  logic [17:0]     rem;
  logic [17:0]     dvs;
  logic [CntW-1:0] div_cnt;
  logic [18:0]     rem_sh;
  logic            div_zero;

  // scan
  logic [VoiceW:0]     idx;
  logic [CountW-1:0]   n;
  logic                f_idle, f_same, f_any;
  logic [VoiceW-1:0]   c_idle, c_same, c_any;
  logic [31:0]         best;
  logic [CountW-1:0]   freed;
  logic [VoiceW-1:0]   vi;
  logic [31:0]         key;
  logic                hit_group;

  assign n  = (voices_in_use > 5'(MaxVoices)) ? CountW'(MaxVoices)
                                              : CountW'(voices_in_use);
  assign vi = idx[VoiceW-1:0];
  assign key = (vend[vi] - req.now_ms) ^ 32'h8000_0000;
  assign hit_group = busy[vi] && (req.group_tag == 16'd0 || vgroup[vi] == req.group_tag);
  assign rem_sh = {rem, quo[NumW-1]};

  assign sts.div_done  = (div_cnt == CntW'(NumW));
  assign sts.scan_done = (CountW'(idx) >= n);
  assign sts.is_play   = (req.mode == MODE_PLAY);

  // capture request; divider shifts
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= req_in;
      quo      <= NumW'(req_in.sample_bytes) * NumW'(1000);
      rem      <= '0;
      dvs      <= 18'(bytes_divisor);
      div_cnt  <= '0;
      div_zero <= (bytes_divisor == 16'd0) || (sample_rate_hz == 18'd0);
    end else if (cmd.div2_init) begin
      rem     <= '0;
      dvs     <= sample_rate_hz;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= 18'(rem_sh - {1'b0, dvs});
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[17:0];
        quo <= {quo[NumW-2:0], 1'b0};
      end
    end
  end

  // advance scan one voice a cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx    <= '0;
      f_idle <= 1'b0;
      f_same <= 1'b0;
      f_any  <= 1'b0;
      c_idle <= '0;
      c_same <= '0;
      c_any  <= '0;
      best   <= '0;
      freed  <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
      if (!busy[vi] && !f_idle) begin
        f_idle <= 1'b1;
        c_idle <= vi;
      end
      if (vsound[vi] == req.sound_index && !loops[vi] && (!f_same || key < best)) begin
        f_same <= 1'b1;
        c_same <= vi;
        best   <= key;
      end
      if (!loops[vi] && !f_any) begin
        f_any <= 1'b1;
        c_any <= vi;
      end
      if (hit_group) freed <= freed + 1'b1;
    end
  end

  // commit: table update and result
  logic [31:0]       next_id;
  logic [31:0]       dur;
  logic              found;
  logic [VoiceW-1:0] ch;
  logic              vin_ok;
  rsp_t              rsp_next;

  always_comb begin
    next_id = id_counter + 32'd1;
    if (next_id == 32'd0) next_id = 32'd1;
    dur = (div_zero || quo[NumW-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
    found = f_idle || f_same || f_any;
    ch = f_idle ? c_idle : (f_same ? c_same : c_any);
    vin_ok = (CountW'(req.voice_in) < n) && busy[req.voice_in[VoiceW-1:0]] &&
             (req.mode == MODE_FINISH || vid[req.voice_in[VoiceW-1:0]] == req.play_id_in);
    // build the result
    rsp_next = '0;
    case (req.mode)
      MODE_PLAY: begin
        if (!found) begin
          rsp_next.status = ST_NO_VOICE;
        end else begin
          rsp_next.voice_out   = 4'(ch);
          rsp_next.stole_voice = !f_idle;
          rsp_next.play_id_out = next_id;
        end
      end
      MODE_FINISH, MODE_STOPID: begin
        if (vin_ok) rsp_next.freed_count = 5'd1;
        else        rsp_next.status      = ST_IGNORED;
      end
      MODE_GROUP: rsp_next.freed_count = 5'(freed);
      default:    rsp_next = '0;
    endcase
  end

  // reset clears the whole voice table and id counter; commit updates them
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= '0;
      loops      <= '0;
      id_counter <= '0;
      for (int i = 0; i < MaxVoices; i++) begin
        vsound[i] <= '0;
        vgroup[i] <= '0;
        vend[i]   <= '0;
        vid[i]    <= '0;
      end
    end else if (cmd.commit) begin
      rsp <= rsp_next;
      case (req.mode)
        MODE_PLAY: begin
          if (found) begin
            id_counter  <= next_id;
            busy[ch]    <= 1'b1;
            loops[ch]   <= req.loop_forever;
            vsound[ch]  <= req.sound_index;
            vgroup[ch]  <= req.group_tag;
            vend[ch]    <= req.now_ms + dur;
            vid[ch]     <= next_id;
          end
        end
        MODE_FINISH, MODE_STOPID: begin
          if (vin_ok) begin
            busy[req.voice_in[VoiceW-1:0]]   <= 1'b0;
            loops[req.voice_in[VoiceW-1:0]]  <= 1'b0;
            vsound[req.voice_in[VoiceW-1:0]] <= '0;
            vgroup[req.voice_in[VoiceW-1:0]] <= '0;
            vend[req.voice_in[VoiceW-1:0]]   <= '0;
            vid[req.voice_in[VoiceW-1:0]]    <= '0;
          end
        end
        MODE_GROUP: begin
          for (int i = 0; i < MaxVoices; i++) begin
            if (i < int'(n) && busy[i] &&
                (req.group_tag == 16'd0 || vgroup[i] == req.group_tag)) begin
              busy[i]   <= 1'b0;
              loops[i]  <= 1'b0;
              vsound[i] <= '0;
              vgroup[i] <= '0;
              vend[i]   <= '0;
              vid[i]    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sv/mva_alloc_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mva_alloc_checker
// Watches the request and result channels of the voice allocator, keeps its
// own copy of the voice table and registers, predicts each result and
// compares it with the whole actual result.
// ---------------------------------------------------------------------------
module mva_alloc_checker import mva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp_data,
  input  logic        cfg_wr,
  input  logic [3:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  logic [4:0]  n_voices;
  logic [17:0] rate_hz;
  logic [15:0] divisor;
  logic        busy   [MaxVoices];
  logic [9:0]  sound  [MaxVoices];
  logic [15:0] group  [MaxVoices];
  logic        loops  [MaxVoices];
  logic [31:0] start  [MaxVoices];
  logic [31:0] length [MaxVoices];
  logic [31:0] pid    [MaxVoices];
  logic [31:0] id_ctr;
  rsp_t        expected_rsp[$];

  assign pending_count = expected_rsp.size();

  // Length in ms, saturated at 32 bits
  function automatic logic [31:0] play_length_ms(logic [31:0] nbytes);
    logic [63:0] q;
    if (divisor == 0 || rate_hz == 0) return 32'hFFFF_FFFF;
    q = 64'(nbytes) * 64'd1000;
    q = q / 64'(divisor);
    q = q / 64'(rate_hz);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic free_voice(int v);
    busy[v] = 0; sound[v] = 0; group[v] = 0; loops[v] = 0;
    start[v] = 0; length[v] = 0; pid[v] = 0;
  endtask

  task automatic allocate(req_t r, output rsp_t o);
    int n, ch;
    bit found;
    logic [31:0] key, best;
    n = (n_voices < MaxVoices) ? n_voices : MaxVoices;
    o = '0; found = 0; ch = 0; best = 0;
    case (r.mode)
      MODE_PLAY: begin
        for (int i = 0; i < n && !found; i++)
          if (!busy[i]) begin ch = i; found = 1; end
        if (!found) begin
          // steal the same sound closest to its end, signed compare
          for (int i = 0; i < n; i++) begin
            if (sound[i] != r.sound_index || loops[i]) continue;
            key = ((start[i] + length[i]) - r.now_ms) ^ 32'h8000_0000;
            if (!found || key < best) begin found = 1; ch = i; best = key; end
          end
          for (int i = 0; i < n && !found; i++)
            if (!loops[i]) begin ch = i; found = 1; end
          if (found) begin
            o.stole_voice = 1;
            free_voice(ch);
          end
        end
        if (!found) o.status = ST_NO_VOICE;
        else begin
          id_ctr++;
          if (id_ctr == 0) id_ctr++;
          busy[ch] = 1; sound[ch] = r.sound_index; group[ch] = r.group_tag;
          loops[ch] = r.loop_forever; start[ch] = r.now_ms;
          length[ch] = play_length_ms(r.sample_bytes); pid[ch] = id_ctr;
          o.voice_out = ch[3:0];
          o.play_id_out = id_ctr;
        end
      end
      MODE_FINISH, MODE_STOPID: begin
        if (r.voice_in < n && busy[r.voice_in] &&
            (r.mode == MODE_FINISH || pid[r.voice_in] == r.play_id_in)) begin
          free_voice(r.voice_in);
          o.freed_count = 1;
        end else o.status = ST_IGNORED;
      end
      default: begin
        for (int i = 0; i < n; i++)
          if (busy[i] && (r.group_tag == 0 || group[i] == r.group_tag)) begin
            free_voice(i);
            o.freed_count++;
          end
      end
    endcase
  endtask

  // Track registers, predict on each request, compare on each result
  always @(posedge clk) begin
    rsp_t p, e;
    if (rst) begin
      n_voices <= 5'd16; rate_hz <= 18'd44100; divisor <= 16'd4;
      for (int i = 0; i < MaxVoices; i++) free_voice(i);
      id_ctr = 0;
      expected_rsp.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr) begin
        case (cfg_addr[3:2])
          REG_VOICES:  n_voices <= cfg_data[4:0];
          REG_RATE:    rate_hz  <= cfg_data[17:0];
          REG_DIVISOR: divisor  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        allocate(req_data, p);
        expected_rsp.push_back(p);
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (e !== rsp_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_mixer_voice_allocator_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mixer_voice_allocator_core
// Drives directed and random allocation requests in bursts through several
// register settings, with random and long result stalls; the checker
// predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_mixer_voice_allocator_core;
  import mva_pkg::*;

  localparam int CycleLimit = 1_500_000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count, pending_count, cycles;
  bit          hold_long, stim_done;
  logic [31:0] now_clock;
  logic [31:0] last_id;
  logic [3:0]  last_voice;

  mva_req_if req_ch ();
  mva_rsp_if rsp_ch ();

  mixer_voice_allocator_core uut (
    .clk, .rst, .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mva_alloc_checker chk (
    .clk, .rst,
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
    .cfg_wr(psel && penable && pwrite && pready), .cfg_addr(paddr),
    .cfg_data(pwdata), .fail_count, .pending_count
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (rst || hold_long) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 15) < 11) || (cycles % 4000 < 600);
  end

  initial begin
    hold_long = 0;
    wait (cycles == 30000);
    hold_long = 1;
    repeat (2000) @(posedge clk);
    hold_long = 0;
  end

  // Remember the last granted voice and id, for well-formed stops
  always @(posedge clk)
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.data.play_id_out != 0) begin
      last_id    <= rsp_ch.data.play_id_out;
      last_voice <= rsp_ch.data.voice_out;
    end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Offer one request and hold it until taken
  task automatic send(req_t r);
    req_ch.valid <= 1; req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic pause_sender();
    req_ch.valid <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic req_t rand_req(int play_pct);
    req_t r;
    r = '0;
    r.mode         = ($urandom_range(0, 99) < play_pct) ? MODE_PLAY
                     : 2'($urandom_range(1, 3));
    r.sound_index  = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3));
    r.sample_bytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400000);
    r.loop_forever = ($urandom_range(0, 4) == 0);
    r.group_tag    = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    r.now_ms       = ($urandom_range(0, 7) == 0) ? $urandom : now_clock;
    r.voice_in     = ($urandom_range(0, 1) != 0) ? last_voice : 4'($urandom);
    r.play_id_in   = ($urandom_range(0, 1) != 0) ? last_id : $urandom;
    return r;
  endfunction

  task automatic random_phase(int count, int play_pct);
    req_t r;
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) pause_sender();
        burst = $urandom_range(1, 20);
      end
      burst--;
      now_clock = now_clock + $urandom_range(0, 300);
      r = rand_req(play_pct);
      send(r);
    end
  endtask

  initial begin
    req_t r;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    req_ch.valid = 0; req_ch.data = '0; cycles = 0; stim_done = 0;
    now_clock = 32'hFFFF_F000; last_id = 0; last_voice = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: few voices, extremes of every field
    reg_write(REG_VOICES, 32'd2);
    reg_write(REG_RATE, 32'd1);
    reg_write(REG_DIVISOR, 32'd1);
    r = '0;
    r.sample_bytes = 32'hFFFF_FFFF; r.group_tag = 16'hFFFF; r.sound_index = 10'h3FF;
    send(r);                                      // saturated length
    r.sample_bytes = 0; r.now_ms = 32'hFFFF_FFFF; send(r);
    r.now_ms = 0; send(r);                        // steal same sound
    r.sound_index = 0; send(r);                   // steal first non-looping
    r.mode = MODE_FINISH; r.voice_in = 4'hF; send(r);   // out of range
    r.voice_in = 0; send(r); send(r);             // free, then idle voice
    r.mode = MODE_STOPID; r.voice_in = 1; r.play_id_in = 32'hFFFF_FFFF; send(r);
    r.play_id_in = 32'd4; send(r);                // id of a freed voice: ignored
    r.mode = MODE_PLAY; r.loop_forever = 1; send(r); send(r);
    send(r);                                      // all looping: no voice
    r.mode = MODE_GROUP; r.group_tag = 16'h1234; send(r);  // empty group
    r.group_tag = 16'hFFFF; send(r);
    r.group_tag = 0; send(r);
    drain();
    reg_write(REG_VOICES, 32'd0);
    r = '0; send(r);                              // no usable voice
    drain();
    reg_write(REG_VOICES, 32'd31);
    reg_write(REG_RATE, 32'h3FFFF);
    reg_write(REG_DIVISOR, 32'hFFFF);
    random_phase(300, 60);
    drain();
    reg_write(REG_RATE, 32'd0);
    random_phase(100, 60);
    drain();
    reg_write(REG_VOICES, 32'd16);
    reg_write(REG_RATE, 32'd192000);
    reg_write(REG_DIVISOR, 32'd1);
    random_phase(700, 70);
    drain();
    reg_write(REG_VOICES, 32'd3);
    reg_write(REG_RATE, 32'd44100);
    reg_write(REG_DIVISOR, 32'd0);
    random_phase(400, 65);
    drain();
    reg_write(REG_VOICES, 32'd1);
    reg_write(REG_DIVISOR, 32'd4);
    random_phase(430, 60);
    drain();
    stim_done = 1;
  end

  // Verdict
  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
